FILE: rtl/scd_pkg.sv
// Shared types and codes for the sync/length/checksum deframer.
`timescale 1ns / 1ps

package scd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;
    localparam logic [1:0] KIND_LONG = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_SYNC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd5;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'd250;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'd255;
    localparam logic [15:0] LIMIT_RST       = 16'd255;

    typedef struct packed {
        logic        two_sync_bytes;
        logic [7:0]  first_sync_value;
        logic [7:0]  second_sync_value;
        logic        two_length_bytes;
        logic        sum_mode;
        logic [15:0] payload_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [15:0] frame_length;
        logic        frame_end;
    } t_result;

endpackage

FILE: rtl/scd_cfg.sv
// Configuration register file of the deframer.
`timescale 1ns / 1ps

module scd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [scd_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0] i_wr_data,
    output scd_pkg::t_cfg                 o_cfg
);
    import scd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_sync_bytes    <= 1'b0;
            r_cfg.first_sync_value  <= SYNC_FIRST_RST;
            r_cfg.second_sync_value <= SYNC_SECOND_RST;
            r_cfg.two_length_bytes  <= 1'b0;
            r_cfg.sum_mode          <= 1'b0;
            r_cfg.payload_limit     <= LIMIT_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_TWO_SYNC:    r_cfg.two_sync_bytes    <= i_wr_data[0];
                CFG_SYNC_FIRST:  r_cfg.first_sync_value  <= i_wr_data[7:0];
                CFG_SYNC_SECOND: r_cfg.second_sync_value <= i_wr_data[7:0];
                CFG_TWO_LEN:     r_cfg.two_length_bytes  <= i_wr_data[0];
                CFG_SUM_MODE:    r_cfg.sum_mode          <= i_wr_data[0];
                CFG_LIMIT:       r_cfg.payload_limit     <= i_wr_data[15:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/scd_fsm.sv
// Frame state machine: sync hunt, length, payload and checksum check.
`timescale 1ns / 1ps

module scd_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  scd_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output scd_pkg::t_result o_res
);
    import scd_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT1   = 3'd0,
        ST_HUNT2   = 3'd1,
        ST_LEN_HI  = 3'd2,
        ST_LEN_LO  = 3'd3,
        ST_PAYLOAD = 3'd4,
        ST_CHK_HI  = 3'd5,
        ST_CHK_LO  = 3'd6
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_len, n_len;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_chk_hi, n_chk_hi;

    logic [15:0] len_full;
    logic [15:0] left_dec;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_left   = r_left;
        n_xor    = r_xor;
        n_sum    = r_sum;
        n_chk_hi = r_chk_hi;
        o_res_valid = 1'b0;
        o_res.out_kind     = KIND_DATA;
        o_res.out_byte     = 8'd0;
        o_res.frame_length = r_len;
        o_res.frame_end    = 1'b0;
        len_full = (r_state == ST_LEN_LO) ? (r_len | {8'd0, i_byte}) : {8'd0, i_byte};
        left_dec = r_left - 16'd1;

        if (i_fire) begin
            unique case (r_state)
                ST_HUNT2, ST_HUNT1: begin
                    if (r_state == ST_HUNT2 && i_byte == i_cfg.second_sync_value) begin
                        n_state = ST_LEN_HI;
                    end else if (i_byte == i_cfg.first_sync_value) begin
                        // start a new frame
                        n_len    = 16'd0;
                        n_left   = 16'd0;
                        n_xor    = 8'd0;
                        n_sum    = 16'd0;
                        n_chk_hi = 8'd0;
                        n_state  = i_cfg.two_sync_bytes ? ST_HUNT2 : ST_LEN_HI;
                    end else begin
                        n_state = ST_HUNT1;
                    end
                end
                ST_LEN_HI, ST_LEN_LO: begin
                    n_xor = r_xor ^ i_byte;
                    n_sum = r_sum + {8'd0, i_byte};
                    if (r_state == ST_LEN_HI && i_cfg.two_length_bytes) begin
                        n_len   = {i_byte, 8'd0};
                        n_state = ST_LEN_LO;
                    end else begin
                        n_len = len_full;
                        if (len_full > i_cfg.payload_limit) begin
                            n_state = ST_HUNT1;
                            o_res_valid        = 1'b1;
                            o_res.out_kind     = KIND_LONG;
                            o_res.frame_length = len_full;
                            o_res.frame_end    = 1'b1;
                        end else begin
                            n_left  = len_full;
                            n_state = (len_full == 16'd0) ? ST_CHK_HI : ST_PAYLOAD;
                        end
                    end
                end
                ST_PAYLOAD: begin
                    n_xor  = r_xor ^ i_byte;
                    n_sum  = r_sum + {8'd0, i_byte};
                    n_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_state = ST_CHK_HI;
                    end
                    o_res_valid    = 1'b1;
                    o_res.out_kind = KIND_DATA;
                    o_res.out_byte = i_byte;
                end
                ST_CHK_HI: begin
                    if (i_cfg.sum_mode) begin
                        n_chk_hi = i_byte;
                        n_state  = ST_CHK_LO;
                    end else begin
                        n_state = ST_HUNT1;
                        o_res_valid     = 1'b1;
                        o_res.out_kind  = (i_byte == r_xor) ? KIND_GOOD : KIND_BAD;
                        o_res.frame_end = 1'b1;
                    end
                end
                ST_CHK_LO: begin
                    n_state = ST_HUNT1;
                    o_res_valid     = 1'b1;
                    o_res.out_kind  = ({r_chk_hi, i_byte} == r_sum) ? KIND_GOOD : KIND_BAD;
                    o_res.frame_end = 1'b1;
                end
                default: begin
                    // unused code behaves as the first sync hunt
                    if (i_byte == i_cfg.first_sync_value) begin
                        n_len    = 16'd0;
                        n_left   = 16'd0;
                        n_xor    = 8'd0;
                        n_sum    = 16'd0;
                        n_chk_hi = 8'd0;
                        n_state  = i_cfg.two_sync_bytes ? ST_HUNT2 : ST_LEN_HI;
                    end else begin
                        n_state = ST_HUNT1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT1;
            r_len    <= 16'd0;
            r_left   <= 16'd0;
            r_xor    <= 8'd0;
            r_sum    <= 16'd0;
            r_chk_hi <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_left   <= n_left;
            r_xor    <= n_xor;
            r_sum    <= n_sum;
            r_chk_hi <= n_chk_hi;
        end
    end

`ifndef SYNTHESIS
    // A payload phase always has bytes still to come.
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAYLOAD |-> r_left != 16'd0)
        else $error("payload phase with no bytes left");

    // Every frame-closing result sends the parser back to the hunt.
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.frame_end |=> r_state == ST_HUNT1)
        else $error("closing result without return to hunt");

    // The hunt phases never produce a result.
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HUNT1 || r_state == ST_HUNT2) |-> !o_res_valid)
        else $error("result during sync hunt");

    // Payload results carry no end flag; status results carry no byte.
    a_kind_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_res.out_kind == KIND_DATA) != o_res.frame_end)
                        && (!o_res.frame_end || o_res.out_byte == 8'd0))
        else $error("malformed result");
`endif

endmodule

FILE: rtl/scd_out.sv
// Output result register with downstream stall handling.
`timescale 1ns / 1ps

module scd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  scd_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_space,
    output logic             o_valid,
    output scd_pkg::t_result o_res
);
    import scd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or when the held one leaves now.
    assign o_space = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/sync_length_checksum_deframer_core.sv
// Top level of the byte-serial sync/length/checksum deframer.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------------------
//  rx in     | in        | i_valid / o_stall      | i_rx_byte
//  result    | out       | o_valid / i_stall      | o_out_kind o_out_byte o_frame_length
//            |           |                        | o_frame_end
//  config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_index i_cfg_data
//
//  One item per cycle sustained while results are not stalled. An accepted item is held in the
//  input register; the frame state machine parses it from there and loads its result (if
//  any) into the output register, from which the result is offered.
//  Reset (i_rst_n low, synchronous) empties both registers, returns the parser
//  to the first sync hunt and loads the default configuration.
//  A stalled result holds the parser; the input register then fills and
//  o_stall rises. Configuration writes are always taken.
//
module sync_length_checksum_deframer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // received bytes
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_rx_byte,
    // results
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_out_kind,
    output logic [7:0]                     o_out_byte,
    output logic [15:0]                    o_frame_length,
    output logic                           o_frame_end,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scd_pkg::*;

    t_cfg    cfg;
    t_result fsm_res;
    t_result out_res;
    logic    fsm_res_valid;
    logic    out_space;
    logic    fire;
    logic    in_take;

    // Input register: holds one received byte until the parser takes it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    assign o_cfg_ready = 1'b1;

    scd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Parse the held byte whenever the output register has room.
    assign fire    = r_in_valid && out_space;
    // Stall upstream only when the held byte cannot advance.
    assign o_stall = r_in_valid && !out_space;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scd_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (fsm_res_valid),
        .o_res       (fsm_res)
    );

    scd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fsm_res_valid),
        .i_res   (fsm_res),
        .i_stall (i_stall),
        .o_space (out_space),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_out_kind     = out_res.out_kind;
    assign o_out_byte     = out_res.out_byte;
    assign o_frame_length = out_res.frame_length;
    assign o_frame_end    = out_res.frame_end;

endmodule
